// ----- rtl/core/ucbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ucbs_pkg
// Shared types and constants of the uniform cubic B-spline sampler.
// ----------------------------------------------------------------------------
package ucbs_pkg;

    localparam int CFG_BITS  = 7;
    localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd16;

    localparam int FRAC_BITS = 16;
    localparam int WQ_BITS   = FRAC_BITS + 1;
    localparam logic [WQ_BITS-1:0] ONE_Q16  = 17'h10000;
    localparam logic [WQ_BITS-1:0] HALF_Q16 = 17'h08000;

    localparam int MAC_STEPS = 8;
    localparam logic [1:0] HELD_FULL = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CUBE2,
        ST_CUBE3,
        ST_J2,
        ST_J3,
        ST_R2,
        ST_R3,
        ST_J2M,
        ST_DIV_A,
        ST_DIV_B,
        ST_DIV_D,
        ST_MAC,
        ST_OUT
    } t_state;

endpackage

// ----- rtl/core/ucbs_if.sv -----
// ----------------------------------------------------------------------------
// ucbs_if
// Valid/ready channels for control points in and curve samples out.
// ----------------------------------------------------------------------------
interface ucbs_pt_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         curve_start;

    modport source (output valid, output point_x, output point_y, output curve_start,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input curve_start,
                    output ready);
endinterface

interface ucbs_smp_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] curve_x;
    logic signed [COORD_BITS-1:0] curve_y;
    logic                         segment_last;

    modport source (output valid, output curve_x, output curve_y, output segment_last,
                    input ready);
    modport sink   (input valid, input curve_x, input curve_y, input segment_last,
                    output ready);
endinterface

// ----- rtl/core/uniform_cubic_bspline_sampler_core.sv -----
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_sampler_core
// Uniform cubic B-spline sampler: one shared multiplier and one shared
// divider under a sequencer blend each four-point window into curve samples.
// ----------------------------------------------------------------------------
// a point that only fills the window is taken in idle, and the block stays idle
// a point that closes a segment runs the cube steps for m, then the n samples in turn
// each sample: 5 multiply steps, 3 divider runs, 9 blend steps, 1 output step
// ready only in idle; one output word register lets the next sample proceed
// reset (synchronous, active low): empty window, idle, samples per segment 16
module uniform_cubic_bspline_sampler_core #(
    parameter int COORD_BITS  = 16,
    parameter int MAX_SAMPLES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ucbs_pkg::CFG_BITS-1:0]       i_cfg_data,
    ucbs_pt_if.sink                             i_pt,
    ucbs_smp_if.source                          o_smp
);

    localparam int C    = COORD_BITS;
    localparam int SB   = $clog2(MAX_SAMPLES);
    localparam int NUMW = 3 * SB + 3;
    localparam int QW   = ucbs_pkg::WQ_BITS;
    localparam int FB   = ucbs_pkg::FRAC_BITS;
    localparam int MA   = (QW > 2 * SB) ? QW : 2 * SB;
    localparam int MB   = (C > SB) ? C : SB;
    localparam int PW   = MA + MB;
    localparam int AW   = QW + C;
    localparam int KW   = $clog2(ucbs_pkg::MAC_STEPS + 1);

    ucbs_pkg::t_state r_state, n_state;

    logic [ucbs_pkg::CFG_BITS-1:0] r_sps;
    logic [1:0]      r_held;
    logic [C-1:0]    r_win_x [3];
    logic [C-1:0]    r_win_y [3];
    logic [C-1:0]    r_px, r_py;
    logic [SB-1:0]   r_m, r_j;
    logic [2*SB-1:0] r_m2, r_j2, r_r2;
    logic [3*SB-1:0] r_m3, r_j3, r_r3, r_j2m;
    logic [NUMW-1:0] r_den, r_bnum;
    logic [QW-1:0]   r_w0, r_w1, r_w2, r_w3;
    logic [KW-1:0]   r_k;
    logic [AW-1:0]   r_prod, r_acc_x, r_acc_y;
    logic            r_ov;
    logic [C-1:0]    r_ox, r_oy;
    logic            r_olast;

    logic            pt_ready;
    logic            pt_take;
    logic            fill;
    logic            div_start;
    logic            div_done;
    logic [QW-1:0]   div_quot;
    logic [NUMW-1:0] div_num;
    logic            slot_free;
    logic            seg_end;
    logic [SB-1:0]   m_cfg;
    logic [SB-1:0]   j_left;
    logic [MA-1:0]   mul_a;
    logic [MB-1:0]   mul_b;
    logic [PW-1:0]   prod;
    logic [QW-1:0]   w_sel;
    logic [C-1:0]    p_sel;
    logic [1:0]      wr_idx;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sps <= ucbs_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_sps <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_sps < 7'd2) begin
            m_cfg = SB'(1);
        end else if (int'(r_sps) > MAX_SAMPLES) begin
            m_cfg = SB'(MAX_SAMPLES - 1);
        end else begin
            m_cfg = SB'(r_sps - 7'd1);
        end
    end

    assign pt_take   = pt_ready && i_pt.valid;
    assign fill      = i_pt.curve_start || (r_held != ucbs_pkg::HELD_FULL);
    assign wr_idx    = i_pt.curve_start ? 2'd0 : r_held;
    assign slot_free = !r_ov || o_smp.ready;
    assign seg_end   = (r_j == r_m);
    assign j_left    = r_m - r_j;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ucbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        pt_ready  = 1'b0;
        div_start = 1'b0;
        case (r_state)
            ucbs_pkg::ST_IDLE: begin
                pt_ready = 1'b1;
                if (i_pt.valid && !fill) begin
                    n_state = ucbs_pkg::ST_CUBE2;
                end
            end
            ucbs_pkg::ST_CUBE2: n_state = ucbs_pkg::ST_CUBE3;
            ucbs_pkg::ST_CUBE3: n_state = ucbs_pkg::ST_J2;
            ucbs_pkg::ST_J2:    n_state = ucbs_pkg::ST_J3;
            ucbs_pkg::ST_J3:    n_state = ucbs_pkg::ST_R2;
            ucbs_pkg::ST_R2:    n_state = ucbs_pkg::ST_R3;
            ucbs_pkg::ST_R3:    n_state = ucbs_pkg::ST_J2M;
            ucbs_pkg::ST_J2M: begin
                div_start = 1'b1;
                n_state   = ucbs_pkg::ST_DIV_A;
            end
            ucbs_pkg::ST_DIV_A: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = ucbs_pkg::ST_DIV_B;
                end
            end
            ucbs_pkg::ST_DIV_B: begin
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = ucbs_pkg::ST_DIV_D;
                end
            end
            ucbs_pkg::ST_DIV_D: begin
                if (div_done) begin
                    n_state = ucbs_pkg::ST_MAC;
                end
            end
            ucbs_pkg::ST_MAC: begin
                if (r_k == KW'(ucbs_pkg::MAC_STEPS)) begin
                    n_state = ucbs_pkg::ST_OUT;
                end
            end
            ucbs_pkg::ST_OUT: begin
                if (slot_free) begin
                    n_state = seg_end ? ucbs_pkg::ST_IDLE : ucbs_pkg::ST_J2;
                end
            end
            default: n_state = ucbs_pkg::ST_IDLE;
        endcase
    end

    // shared divider
    always_comb begin
        case (r_state)
            ucbs_pkg::ST_J2M:   div_num = NUMW'(r_r3);
            ucbs_pkg::ST_DIV_A: div_num = r_bnum;
            default:            div_num = NUMW'(r_j3);
        endcase
    end

    ucbs_div #(
        .NUM_BITS (NUMW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // shared multiplier
    always_comb begin
        case (r_k[1:0])
            2'd0:    w_sel = r_w0;
            2'd1:    w_sel = r_w1;
            2'd2:    w_sel = r_w2;
            default: w_sel = r_w3;
        endcase
        case (r_k[1:0])
            2'd0:    p_sel = r_k[2] ? r_win_y[0] : r_win_x[0];
            2'd1:    p_sel = r_k[2] ? r_win_y[1] : r_win_x[1];
            2'd2:    p_sel = r_k[2] ? r_win_y[2] : r_win_x[2];
            default: p_sel = r_k[2] ? r_py : r_px;
        endcase
        // offset binary: sign bit flipped
        p_sel[C-1] = ~p_sel[C-1];
    end

    always_comb begin
        case (r_state)
            ucbs_pkg::ST_CUBE2: begin
                mul_a = MA'(r_m);
                mul_b = MB'(r_m);
            end
            ucbs_pkg::ST_CUBE3: begin
                mul_a = MA'(r_m2);
                mul_b = MB'(r_m);
            end
            ucbs_pkg::ST_J2: begin
                mul_a = MA'(r_j);
                mul_b = MB'(r_j);
            end
            ucbs_pkg::ST_J3: begin
                mul_a = MA'(r_j2);
                mul_b = MB'(r_j);
            end
            ucbs_pkg::ST_R2: begin
                mul_a = MA'(j_left);
                mul_b = MB'(j_left);
            end
            ucbs_pkg::ST_R3: begin
                mul_a = MA'(r_r2);
                mul_b = MB'(j_left);
            end
            ucbs_pkg::ST_J2M: begin
                mul_a = MA'(r_j2);
                mul_b = MB'(r_m);
            end
            ucbs_pkg::ST_MAC: begin
                mul_a = MA'(w_sel);
                mul_b = MB'(p_sel);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {{MB{1'b0}}, mul_a} * {{MA{1'b0}}, mul_b};

    // window fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (pt_take && fill) begin
            r_held <= wr_idx + 2'd1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (pt_take) begin
            if (fill) begin
                r_win_x[wr_idx] <= i_pt.point_x;
                r_win_y[wr_idx] <= i_pt.point_y;
            end else begin
                r_px <= i_pt.point_x;
                r_py <= i_pt.point_y;
                r_m  <= m_cfg;
                r_j  <= '0;
            end
        end
        case (r_state)
            ucbs_pkg::ST_CUBE2: r_m2 <= prod[2*SB-1:0];
            ucbs_pkg::ST_CUBE3: r_m3 <= prod[3*SB-1:0];
            ucbs_pkg::ST_J2: begin
                r_j2  <= prod[2*SB-1:0];
                r_den <= NUMW'({r_m3, 2'b00}) + NUMW'({r_m3, 1'b0});
            end
            ucbs_pkg::ST_J3:  r_j3  <= prod[3*SB-1:0];
            ucbs_pkg::ST_R2:  r_r2  <= prod[2*SB-1:0];
            ucbs_pkg::ST_R3:  r_r3  <= prod[3*SB-1:0];
            ucbs_pkg::ST_J2M: r_j2m <= prod[3*SB-1:0];
            ucbs_pkg::ST_DIV_A: begin
                // 3 j^3 + 4 m^3 - 6 j^2 m
                r_bnum <= NUMW'({r_j3, 1'b0}) + NUMW'(r_j3) + NUMW'({r_m3, 2'b00})
                        - NUMW'({r_j2m, 2'b00}) - NUMW'({r_j2m, 1'b0});
                if (div_done) begin
                    r_w0 <= div_quot;
                end
            end
            ucbs_pkg::ST_DIV_B: begin
                if (div_done) begin
                    r_w1 <= div_quot;
                end
            end
            ucbs_pkg::ST_DIV_D: begin
                if (div_done) begin
                    r_w3 <= div_quot;
                    r_w2 <= ucbs_pkg::ONE_Q16 - r_w0 - r_w1 - div_quot;
                    r_k  <= '0;
                end
            end
            ucbs_pkg::ST_MAC: begin
                r_prod <= prod[AW-1:0];
                r_k    <= r_k + 1'b1;
                if (r_k == '0) begin
                    r_acc_x <= AW'(ucbs_pkg::HALF_Q16);
                    r_acc_y <= AW'(ucbs_pkg::HALF_Q16);
                end else if (r_k <= KW'(ucbs_pkg::MAC_STEPS / 2)) begin
                    r_acc_x <= r_acc_x + r_prod;
                end else begin
                    r_acc_y <= r_acc_y + r_prod;
                end
            end
            ucbs_pkg::ST_OUT: begin
                if (slot_free) begin
                    if (seg_end) begin
                        r_win_x[0] <= r_win_x[1];
                        r_win_x[1] <= r_win_x[2];
                        r_win_x[2] <= r_px;
                        r_win_y[0] <= r_win_y[1];
                        r_win_y[1] <= r_win_y[2];
                        r_win_y[2] <= r_py;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ucbs_pkg::ST_OUT && slot_free) begin
            r_ov <= 1'b1;
        end else if (o_smp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ucbs_pkg::ST_OUT && slot_free) begin
            r_ox    <= {~r_acc_x[FB+C-1], r_acc_x[FB+C-2:FB]};
            r_oy    <= {~r_acc_y[FB+C-1], r_acc_y[FB+C-2:FB]};
            r_olast <= seg_end;
        end
    end

    assign i_pt.ready         = pt_ready;
    assign o_smp.valid        = r_ov;
    assign o_smp.curve_x      = r_ox;
    assign o_smp.curve_y      = r_oy;
    assign o_smp.segment_last = r_olast;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ucbs_pkg::ST_DIV_A || r_state == ucbs_pkg::ST_DIV_B
                      || r_state == ucbs_pkg::ST_DIV_D))
        else $error("divider finished outside a divide step");

    a_sample_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ucbs_pkg::ST_IDLE) |-> (r_j <= r_m))
        else $error("sample index beyond segment end");

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ucbs_pkg::ST_MAC) |-> (r_k <= KW'(ucbs_pkg::MAC_STEPS)))
        else $error("blend step count overrun");

    a_out_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ucbs_pkg::ST_OUT) |-> ($past(r_state) == ucbs_pkg::ST_MAC
                                           || $past(r_state) == ucbs_pkg::ST_OUT))
        else $error("output step entered without blend");
`endif

endmodule

// ----- rtl/core/ucbs_div.sv -----
// ----------------------------------------------------------------------------
// ucbs_div
// Restoring divider, one quotient bit per cycle: round(num * 2^16 / den).
// ----------------------------------------------------------------------------
module ucbs_div #(
    parameter int NUM_BITS = 21
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_BITS-1:0]          i_num,
    input  logic [NUM_BITS-1:0]          i_den,
    output logic                         o_done,
    output logic [ucbs_pkg::WQ_BITS-1:0] o_quot
);

    localparam int QW   = ucbs_pkg::WQ_BITS;
    localparam int DVW  = NUM_BITS + QW;
    localparam int CNTW = $clog2(QW);

    logic [DVW-1:0]      dividend;
    logic [NUM_BITS:0]   trial;
    logic [NUM_BITS:0]   diff;
    logic                ge;

    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_den;
    logic [QW-1:0]       r_q;
    logic [CNTW-1:0]     r_cnt;
    logic                r_busy;
    logic                r_done;

    // half the divisor added up front rounds halves up
    assign dividend = {1'b0, i_num, {ucbs_pkg::FRAC_BITS{1'b0}}} + DVW'(i_den >> 1);
    assign trial    = {r_rem, r_q[QW-1]};
    assign diff     = trial - {1'b0, r_den};
    assign ge       = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= dividend[DVW-1:QW];
            r_q   <= dividend[QW-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[NUM_BITS-1:0] : trial[NUM_BITS-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the uniform cubic B-spline sampler core. Control
// points go in over the point channel with random gaps, curve samples are
// taken with random stalls, and every sample word is checked against an
// in-bench blend of the four-point window with Q1.16 weights.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS      = 16;
    localparam int MAX_SAMPLES     = 64;
    localparam int RANDOM_POINTS   = 240;
    localparam int SETTLE_CYCLES   = 20;
    localparam int TAIL_CYCLES     = 100;
    localparam longint CYCLE_LIMIT = 8000000;
    localparam longint unsigned WEIGHT_ONE = 64'd65536;
    localparam longint unsigned HALF_LSB   = 64'd32768;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last;
    } t_sample;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [ucbs_pkg::CFG_BITS-1:0] i_cfg_data;

    ucbs_pt_if  #(.COORD_BITS(COORD_BITS)) pt_if ();
    ucbs_smp_if #(.COORD_BITS(COORD_BITS)) smp_if ();

    uniform_cubic_bspline_sampler_core #(
        .COORD_BITS (COORD_BITS),
        .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_pt      (pt_if),
        .o_smp     (smp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state
    logic [ucbs_pkg::CFG_BITS-1:0] samples_reg;
    logic [2:0][COORD_BITS-1:0]    win_x;
    logic [2:0][COORD_BITS-1:0]    win_y;
    int                            held;

    t_sample expected_samples[$];
    int      error_count;
    longint  cycle_count;
    bit      quiet_send;
    bit      quiet_recv;

    function automatic int draw_wait(bit quiet);
        if (quiet) return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic longint unsigned q16_weight(longint unsigned num, longint unsigned den);
        return (num * WEIGHT_ONE + den / 2) / den;
    endfunction

    // coordinates blended with an offset so the sum stays unsigned
    function automatic logic [COORD_BITS-1:0] blend_coord(logic [3:0][COORD_BITS-1:0] p,
                                                          logic [3:0][63:0] w);
        longint unsigned acc;
        acc = 0;
        for (int i = 0; i < 4; i++) begin
            acc += w[i] * {48'd0, p[i] ^ 16'h8000};
        end
        acc = (acc + HALF_LSB) >> 16;
        return acc[COORD_BITS-1:0] ^ 16'h8000;
    endfunction

    function automatic void advance_curve(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                          logic start);
        longint unsigned            n, m, den, r, bnum, wa, wb, wc, wd;
        logic [3:0][COORD_BITS-1:0] px, py;
        t_sample                    s;
        if (start) begin
            win_x = '0;
            win_y = '0;
            held  = 0;
        end
        if (held < 3) begin
            win_x[held] = x;
            win_y[held] = y;
            held++;
            return;
        end
        n = 64'(samples_reg);
        if (n < 2) n = 2;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        m   = n - 1;
        den = 6 * m * m * m;
        px  = {x, win_x[2], win_x[1], win_x[0]};
        py  = {y, win_y[2], win_y[1], win_y[0]};
        for (longint unsigned j = 0; j < n; j++) begin
            r    = m - j;
            bnum = 3 * j * j * j + 4 * m * m * m - 6 * j * j * m;
            wa   = q16_weight(r * r * r, den);
            wb   = q16_weight(bnum, den);
            wd   = q16_weight(j * j * j, den);
            wc   = WEIGHT_ONE - wa - wb - wd;
            s.x    = blend_coord(px, {wd, wc, wb, wa});
            s.y    = blend_coord(py, {wd, wc, wb, wa});
            s.last = (j == m);
            expected_samples.push_back(s);
        end
        win_x = {x, win_x[2], win_x[1]};
        win_y = {y, win_y[2], win_y[1]};
    endfunction

    task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y, input logic start);
        int gap;
        gap = draw_wait(quiet_send);
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid       <= 1'b1;
        pt_if.point_x     <= x;
        pt_if.point_y     <= y;
        pt_if.curve_start <= start;
        do @(posedge i_clk); while (!pt_if.ready);
        advance_curve(x, y, start);
    endtask

    task automatic drain_block();
        pt_if.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_samples_reg(input logic [ucbs_pkg::CFG_BITS-1:0] value);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        samples_reg = value;
    endtask

    function automatic logic [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 31)) - 16'd16;
            default: return 16'($urandom());
        endcase
    endfunction

    // reset value of the register, window filled from the zero state
    task automatic test_fill_from_reset();
        send_point(16'sh7fff, -16'sh8000, 1'b0);
        send_point(-16'sh8000, 16'sh7fff, 1'b0);
        send_point(16'sh0000, -16'sh0001, 1'b0);
        send_point(16'sh7fff, 16'sh7fff, 1'b0);
        send_point(-16'sh8000, -16'sh8000, 1'b0);
    endtask

    // restart on a full window and in the middle of filling
    task automatic test_curve_restart();
        send_point(16'sd1, 16'sd2, 1'b1);
        send_point(16'sd3, -16'sd4, 1'b0);
        send_point(16'sd5, 16'sd6, 1'b1);
        send_point(-16'sd700, 16'sd800, 1'b0);
        send_point(16'sd9000, -16'sd10000, 1'b0);
        send_point(16'sd11, 16'sd12, 1'b0);
    endtask

    // flat window at the extremes, then full swings
    task automatic test_constant_window();
        send_point(-16'sh8000, 16'sh7fff, 1'b1);
        repeat (3) send_point(-16'sh8000, 16'sh7fff, 1'b0);
        repeat (3) send_point(16'sh7fff, -16'sh8000, 1'b0);
    endtask

    task automatic test_register_extremes();
        logic [ucbs_pkg::CFG_BITS-1:0] values[7];
        values = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd64, 7'd65, 7'd127};
        quiet_send = 1'b1;
        quiet_recv = 1'b1;
        foreach (values[i]) begin
            write_samples_reg(values[i]);
            send_point(rand_coord(), rand_coord(), 1'b0);
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    task automatic test_random_curves();
        int                            sent_total;
        int                            sent_phase;
        int                            phase_points;
        int                            curve_len;
        logic                          start;
        logic [ucbs_pkg::CFG_BITS-1:0] value;
        sent_total = 0;
        while (sent_total < RANDOM_POINTS) begin
            case ($urandom_range(0, 9))
                0:       value = 7'($urandom_range(0, 1));
                1:       value = 7'($urandom_range(64, 127));
                2:       value = 7'($urandom_range(13, 40));
                default: value = 7'($urandom_range(2, 12));
            endcase
            write_samples_reg(value);
            phase_points = (value > 40) ? 6 : $urandom_range(15, 30);
            sent_phase   = 0;
            while (sent_phase < phase_points) begin
                quiet_send = ($urandom_range(0, 4) == 0);
                quiet_recv = ($urandom_range(0, 4) == 0);
                curve_len  = $urandom_range(4, 10);
                for (int k = 0; k < curve_len; k++) begin
                    start = (k == 0);
                    // stray restarts and missing starts
                    if ($urandom_range(0, 24) == 0) start = ~start;
                    send_point(rand_coord(), rand_coord(), start);
                end
                sent_phase += curve_len;
            end
            sent_total += sent_phase;
        end
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        pt_if.valid       = 1'b0;
        pt_if.point_x     = '0;
        pt_if.point_y     = '0;
        pt_if.curve_start = 1'b0;
        error_count       = 0;
        quiet_send        = 1'b0;
        quiet_recv        = 1'b0;
        samples_reg       = ucbs_pkg::CFG_RESET;
        win_x             = '0;
        win_y             = '0;
        held              = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_from_reset();
        test_curve_restart();
        test_constant_window();
        test_register_extremes();
        test_random_curves();

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // sample word checker with random stalls
    initial begin : sample_monitor
        int      stall;
        t_sample want;
        stall        = 0;
        smp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && smp_if.valid && smp_if.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample word with nothing expected: x %0d y %0d",
                           $signed(smp_if.curve_x), $signed(smp_if.curve_y));
                    error_count++;
                end else begin
                    want = expected_samples.pop_front();
                    if (smp_if.curve_x !== want.x) begin
                        $error("curve_x: expected %0d, got %0d",
                               $signed(want.x), $signed(smp_if.curve_x));
                        error_count++;
                    end
                    if (smp_if.curve_y !== want.y) begin
                        $error("curve_y: expected %0d, got %0d",
                               $signed(want.y), $signed(smp_if.curve_y));
                        error_count++;
                    end
                    if (smp_if.segment_last !== want.last) begin
                        $error("segment_last: expected %0b, got %0b",
                               want.last, smp_if.segment_last);
                        error_count++;
                    end
                end
                stall = draw_wait(quiet_recv);
                if (stall > 0) smp_if.ready <= 1'b0;
            end else if (!smp_if.ready) begin
                if (stall == 0) begin
                    smp_if.ready <= 1'b1;
                end else begin
                    stall--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule
